// ===== rtl/fqs_pkg.sv =====
// Shared types and constants of the FIFO queue with content search.
package fqs_pkg;

  localparam int DEPTH_DEF   = 64;
  localparam int VALUE_W     = 32;
  localparam int ACTION_W    = 2;
  localparam int STATUS_W    = 2;
  localparam int OCC_W       = 7;
  localparam int IN_TDATA_W  = 32;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_PAD_W   = 6;
  localparam int OUT_TDATA_W = 48;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ENQ    = 2'd0,
    ACT_DEQ    = 2'd1,
    ACT_LIST   = 2'd2,
    ACT_SEARCH = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEQ_OUT,
    S_LIST_RD,
    S_LIST_OUT,
    S_SRCH_RD,
    S_SRCH_CMP,
    S_SRCH_DONE
  } state_t;

  typedef struct packed {
    action_t                   op;
    logic signed [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] data;
    status_t                   status;
    logic                      found;
    logic [OCC_W-1:0]          occupancy;
    logic                      last;
  } result_t;

endpackage

// ===== rtl/fqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module fqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/fqs_front.sv =====
// Front end: accepts input transactions, decodes the operation and queues commands.
module fqs_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [fqs_pkg::IN_TDATA_W-1:0] in_tdata,
  input  logic [fqs_pkg::IN_TUSER_W-1:0] in_tuser,
  output logic                          cmd_valid,
  output fqs_pkg::cmd_t                 cmd,
  input  logic                          cmd_pop
);
  import fqs_pkg::*;

  cmd_t       q_r [2];
  logic       wptr_r, wptr_nxt;
  logic       rptr_r, rptr_nxt;
  logic [1:0] fill_r, fill_nxt;
  logic       push;
  cmd_t       in_cmd;

  always_comb begin
    in_cmd.value = $signed(in_tdata[VALUE_W-1:0]);
    case (action_t'(in_tuser))
      ACT_ENQ:    in_cmd.op = ACT_ENQ;
      ACT_DEQ:    in_cmd.op = ACT_DEQ;
      ACT_LIST:   in_cmd.op = ACT_LIST;
      ACT_SEARCH: in_cmd.op = ACT_SEARCH;
      default:    in_cmd.op = ACT_ENQ;
    endcase
  end

  assign in_tready = (fill_r != 2'd2);
  assign push      = in_tvalid && in_tready;
  assign cmd_valid = (fill_r != 2'd0);
  assign cmd       = q_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = cmd_pop ? ~rptr_r : rptr_r;
    fill_nxt = fill_r + 2'(push) - 2'(cmd_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      fill_r <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wptr_r] <= in_cmd;
    end
  end

endmodule

// ===== rtl/fqs_back.sv =====
// Back end: ring storage, head and count, and the sequencer that produces results.
module fqs_back #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cmd_valid,
  input  fqs_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  output logic             res_valid,
  input  logic             res_ready,
  output fqs_pkg::result_t res
);
  import fqs_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [IDX_W:0]   SUM_DEPTH = (IDX_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(DEPTH);

  state_t                    state_r, state_nxt;
  logic [IDX_W-1:0]          head_r, head_nxt;
  logic [CNT_W-1:0]          count_r, count_nxt;
  logic [CNT_W-1:0]          idx_r, idx_nxt;
  logic                      hit_r, hit_nxt;
  logic signed [VALUE_W-1:0] key_r, key_nxt;
  logic                      out_valid_r, out_valid_nxt;
  result_t                   res_r, res_nxt;

  logic                      slot_free;
  logic                      idx_is_last;
  logic [CNT_W-1:0]          idx_inc;
  logic                      ram_we, ram_re;
  logic [IDX_W-1:0]          ram_waddr, ram_raddr, rd_off;
  logic [VALUE_W-1:0]        ram_rdata;

  function automatic logic [IDX_W-1:0] ring_pos(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= SUM_DEPTH) begin
      sum = sum - SUM_DEPTH;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign slot_free   = !out_valid_r || res_ready;
  assign idx_inc     = idx_r + 1'b1;
  assign idx_is_last = (idx_inc == count_r);
  assign rd_off      = (state_r == S_IDLE) ? '0 : idx_r[IDX_W-1:0];
  assign ram_raddr   = ring_pos(head_r, rd_off);
  assign ram_waddr   = ring_pos(head_r, count_r[IDX_W-1:0]);

  fqs_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (key_nxt),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            ACT_DEQ: begin
              if (count_r != '0) state_nxt = S_DEQ_OUT;
            end
            ACT_LIST: begin
              if (count_r != '0) state_nxt = S_LIST_RD;
            end
            ACT_SEARCH: begin
              state_nxt = (count_r == '0) ? S_SRCH_DONE : S_SRCH_RD;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_DEQ_OUT: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      S_LIST_RD:  state_nxt = S_LIST_OUT;
      S_LIST_OUT: begin
        if (slot_free) state_nxt = idx_is_last ? S_IDLE : S_LIST_RD;
      end
      S_SRCH_RD:  state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: state_nxt = idx_is_last ? S_SRCH_DONE : S_SRCH_RD;
      S_SRCH_DONE: begin
        if (slot_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    hit_nxt       = hit_r;
    key_nxt       = cmd.value;
    out_valid_nxt = out_valid_r && !res_ready;
    res_nxt       = res_r;
    cmd_pop       = 1'b0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    if (state_r != S_IDLE) begin
      key_nxt = key_r;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            ACT_ENQ: begin
              if (slot_free) begin
                cmd_pop        = 1'b1;
                out_valid_nxt  = 1'b1;
                res_nxt.data   = '0;
                res_nxt.found  = 1'b0;
                res_nxt.last   = 1'b1;
                if (count_r == CNT_FULL) begin
                  res_nxt.status    = ST_FULL;
                  res_nxt.occupancy = OCC_W'(count_r);
                end else begin
                  ram_we            = 1'b1;
                  count_nxt         = count_r + 1'b1;
                  res_nxt.status    = ST_OK;
                  res_nxt.occupancy = OCC_W'(count_nxt);
                end
              end
            end
            ACT_DEQ: begin
              if (count_r != '0) begin
                cmd_pop = 1'b1;
                ram_re  = 1'b1;
              end else if (slot_free) begin
                cmd_pop           = 1'b1;
                out_valid_nxt     = 1'b1;
                res_nxt.data      = -32'sd1;
                res_nxt.status    = ST_EMPTY;
                res_nxt.found     = 1'b0;
                res_nxt.occupancy = '0;
                res_nxt.last      = 1'b1;
              end
            end
            ACT_LIST: begin
              if (count_r != '0) begin
                cmd_pop = 1'b1;
                idx_nxt = '0;
              end else if (slot_free) begin
                cmd_pop           = 1'b1;
                out_valid_nxt     = 1'b1;
                res_nxt.data      = '0;
                res_nxt.status    = ST_EMPTY;
                res_nxt.found     = 1'b0;
                res_nxt.occupancy = '0;
                res_nxt.last      = 1'b1;
              end
            end
            ACT_SEARCH: begin
              cmd_pop = 1'b1;
              idx_nxt = '0;
              hit_nxt = 1'b0;
            end
            default: cmd_pop = 1'b0;
          endcase
        end
      end
      S_DEQ_OUT: begin
        if (slot_free) begin
          head_nxt          = ring_pos(head_r, IDX_W'(1));
          count_nxt         = count_r - 1'b1;
          out_valid_nxt     = 1'b1;
          res_nxt.data      = $signed(ram_rdata);
          res_nxt.status    = ST_OK;
          res_nxt.found     = 1'b0;
          res_nxt.occupancy = OCC_W'(count_nxt);
          res_nxt.last      = 1'b1;
        end
      end
      S_LIST_RD: ram_re = 1'b1;
      S_LIST_OUT: begin
        if (slot_free) begin
          idx_nxt           = idx_inc;
          out_valid_nxt     = 1'b1;
          res_nxt.data      = $signed(ram_rdata);
          res_nxt.status    = ST_OK;
          res_nxt.found     = 1'b0;
          res_nxt.occupancy = OCC_W'(count_r);
          res_nxt.last      = idx_is_last;
        end
      end
      S_SRCH_RD: ram_re = 1'b1;
      S_SRCH_CMP: begin
        idx_nxt = idx_inc;
        if ($signed(ram_rdata) == key_r) hit_nxt = 1'b1;
      end
      S_SRCH_DONE: begin
        if (slot_free) begin
          out_valid_nxt     = 1'b1;
          res_nxt.data      = '0;
          res_nxt.status    = ST_OK;
          res_nxt.found     = hit_r;
          res_nxt.occupancy = OCC_W'(count_r);
          res_nxt.last      = 1'b1;
        end
      end
      default: cmd_pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
    res_r <= res_nxt;
  end

  assign res_valid = out_valid_r;
  assign res       = res_r;

endmodule

// ===== rtl/fifo_queue_with_search_core.sv =====
// FIFO queue of signed values with list and content search; one result stream out.
// Enqueue, empty dequeue and empty list answer from the idle state; dequeue reads the store
// first, search reads and compares every entry, and list reads each entry before its result.
// An enqueue can be taken every cycle while the result stream is not stalled; the back end's
// single read port of the store sets the pace of dequeue, list and search. A two-entry command
// queue decouples the sides. Synchronous active-low reset empties the queue, not the store.
module fifo_queue_with_search_core #(
  parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // value[31:0]
  input  logic [fqs_pkg::IN_TDATA_W-1:0]  in_tdata,
  // action[1:0]
  input  logic [fqs_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // data[31:0], status[33:32], found[34], occupancy[41:35], zero padding[47:42]
  output logic [fqs_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic                           out_tlast
);
  import fqs_pkg::*;

  logic    cmd_valid;
  cmd_t    cmd;
  logic    cmd_pop;
  result_t res;

  fqs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  fqs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_valid (out_tvalid),
    .res_ready (out_tready),
    .res       (res)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, res.occupancy, res.found, res.status, res.data};
  assign out_tlast = res.last;

endmodule
